[rtl/pcpa_pkg.sv]
package pcpa_pkg;

    localparam int ADDR_W     = 40;
    localparam int CPU_ID_W   = 3;
    localparam int LINK_W     = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int CFG_IDX_W  = 1;

    localparam logic [ADDR_W-1:0] MEM_LOW_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] MEM_TOP_RST = 40'h00_8800_0000;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEM_LOW = 1'b0,
        REG_MEM_TOP = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_POP
    } t_state;

    // Command from the sequencer to the head registers.
    typedef struct packed {
        logic              latch;
        logic              is_free;
        logic              wr_en;
        logic [LINK_W-1:0] wr_val;
    } t_head_cmd;

    // Head of the list chosen for the request on the input port.
    typedef struct packed {
        logic              found;
        logic [LINK_W-1:0] head;
    } t_head_view;

endpackage

[rtl/pcpa_if.sv]
interface pcpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [pcpa_pkg::CPU_ID_W-1:0] cpu_id;
    logic [pcpa_pkg::ADDR_W-1:0]   page_addr;

    modport source (output valid, req_type, cpu_id, page_addr, input ready);
    modport sink   (input valid, req_type, cpu_id, page_addr, output ready);
endinterface

interface pcpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pcpa_pkg::ADDR_W-1:0] alloc_addr;
    logic                        granted;
    logic                        bad_free;

    modport source (output valid, alloc_addr, granted, bad_free, input ready);
    modport sink   (input valid, alloc_addr, granted, bad_free, output ready);
endinterface

interface pcpa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pcpa_pkg::CFG_IDX_W-1:0] index;
    logic [pcpa_pkg::ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pcpa_ram.sv]
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pcpa_heads.sv]
module pcpa_heads #(
    parameter int CPU_COUNT = 8,
    parameter int CPU_W     = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pcpa_pkg::CPU_ID_W-1:0]   i_cpu_id,
    input  pcpa_pkg::t_head_cmd             i_cmd,
    output pcpa_pkg::t_head_view            o_pick,
    output logic [pcpa_pkg::LINK_W-1:0]     o_held
);
    import pcpa_pkg::*;

    logic [LINK_W-1:0]    r_heads [CPU_COUNT];
    logic [CPU_W-1:0]     r_sel;
    logic [CPU_W-1:0]     n_sel;
    logic [LINK_W-1:0]    r_held;
    logic [CPU_COUNT-1:0] nonempty;
    logic                 cpu_ok;
    logic                 own_busy;
    logic [CPU_W-1:0]     cpu_idx;
    logic [CPU_W-1:0]     low_idx;

    // A free goes to the requester's own list. An allocate takes the
    // requester's list when it holds a page, else the lowest non-empty list.
    always_comb begin
        cpu_ok   = int'(i_cpu_id) < CPU_COUNT;
        cpu_idx  = CPU_W'(i_cpu_id);
        own_busy = 1'b0;
        low_idx  = '0;
        for (int c = 0; c < CPU_COUNT; c++) begin
            nonempty[c] = r_heads[c] != '0;
        end
        for (int c = 0; c < CPU_COUNT; c++) begin
            if (int'(i_cpu_id) == c) begin
                own_busy = nonempty[c];
            end
        end
        for (int c = CPU_COUNT - 1; c >= 0; c--) begin
            if (nonempty[c]) begin
                low_idx = CPU_W'(c);
            end
        end
        if (i_cmd.is_free) begin
            n_sel = cpu_ok ? cpu_idx : '0;
        end else begin
            n_sel = own_busy ? cpu_idx : low_idx;
        end
        o_pick.head  = r_heads[n_sel];
        o_pick.found = nonempty[n_sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CPU_COUNT; c++) begin
                r_heads[c] <= '0;
            end
            r_sel <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                r_heads[r_sel] <= i_cmd.wr_val;
            end
            if (i_cmd.latch) begin
                r_sel <= n_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_held <= o_pick.head;
        end
    end

    assign o_held = r_held;

endmodule

[rtl/pcpa_addr.sv]
module pcpa_addr #(
    parameter int PAGE_COUNT = 32768,
    parameter int IDX_W      = 15
) (
    input  logic [pcpa_pkg::ADDR_W-1:0] i_mem_low,
    input  logic [pcpa_pkg::ADDR_W-1:0] i_mem_top,
    input  logic [pcpa_pkg::ADDR_W-1:0] i_addr,
    input  logic [pcpa_pkg::LINK_W-1:0] i_page,
    output logic                        o_free_ok,
    output logic [IDX_W-1:0]            o_free_idx,
    output logic [pcpa_pkg::LINK_W-1:0] o_free_link,
    output logic [pcpa_pkg::ADDR_W-1:0] o_page_addr
);
    import pcpa_pkg::*;

    localparam int PN_W = ADDR_W - PAGE_SHIFT;

    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] diff;
    logic [PN_W-1:0]   page_num;
    logic [ADDR_W-1:0] offset;
    logic [LINK_W-1:0] page_m1;

    always_comb begin
        base        = {i_mem_low[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        diff        = i_addr - base;
        page_num    = diff[ADDR_W-1:PAGE_SHIFT];
        o_free_ok   = (i_addr[PAGE_SHIFT-1:0] == '0) && (i_addr >= i_mem_low)
                      && (i_addr < i_mem_top) && (page_num < PN_W'(PAGE_COUNT));
        o_free_idx  = page_num[IDX_W-1:0];
        o_free_link = LINK_W'(page_num[IDX_W-1:0]) + LINK_W'(1);
        page_m1     = i_page - LINK_W'(1);
        offset      = ADDR_W'(page_m1) << PAGE_SHIFT;
        o_page_addr = base + offset;
    end

endmodule

[rtl/per_cpu_page_free_list_allocator.sv]
// Channel   Dir  Payload                          Meaning
// i_req     in   req_type, cpu_id, page_addr      allocate or free request
// o_rsp     out  alloc_addr, granted, bad_free    one result per request
// i_cfg     in   index, data                      mem_low / mem_top writes
//
// Every request transaction has an accept step, which picks a list and issues
// the read of the link memory, and a finishing step, which takes the read data
// (allocate) or checks the address and writes the link (free).
// Reset empties every list at once; the link memory is not cleared, since a link
// is always written when its page is pushed, before any pop reads it.
// A new request is accepted while an earlier result waits in the output register;
// the finishing step holds until that register is free.
module per_cpu_page_free_list_allocator #(
    parameter int CPU_COUNT  = 8,
    parameter int PAGE_COUNT = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcpa_req_if.sink    i_req,
    pcpa_rsp_if.source  o_rsp,
    pcpa_cfg_if.sink    i_cfg
);
    import pcpa_pkg::*;

    localparam int CPU_W = CPU_COUNT > 1 ? $clog2(CPU_COUNT) : 1;
    localparam int IDX_W = PAGE_COUNT > 1 ? $clog2(PAGE_COUNT) : 1;

    // Configuration registers.
    logic [ADDR_W-1:0] r_mem_low;
    logic [ADDR_W-1:0] r_mem_top;

    // Sequencer state and the request held for its finishing step.
    t_state            r_state;
    t_state            n_state;
    logic              r_found;
    logic              r_cpu_ok;
    logic [ADDR_W-1:0] r_addr;

    // Output register.
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_alloc_addr;
    logic              r_granted;
    logic              r_bad_free;

    logic              in_take;
    logic              out_free;
    logic              load_out;
    logic [ADDR_W-1:0] n_alloc_addr;
    logic              n_granted;
    logic              n_bad_free;

    t_head_cmd         head_cmd;
    t_head_view        pick;
    logic [LINK_W-1:0] held;

    logic              ram_we;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    logic              free_ok;
    logic [IDX_W-1:0]  free_idx;
    logic [LINK_W-1:0] free_link;
    logic [ADDR_W-1:0] page_addr;
    logic [LINK_W-1:0] addr_page;

    pcpa_heads #(
        .CPU_COUNT (CPU_COUNT),
        .CPU_W     (CPU_W)
    ) u_heads (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cpu_id (i_req.cpu_id),
        .i_cmd    (head_cmd),
        .o_pick   (pick),
        .o_held   (held)
    );

    // The link memory: entry i holds the successor of page i, plus one.
    pcpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (PAGE_COUNT)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_idx),
        .i_wdata (held),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The address unit is fed the held head register; that head
    // is the value that was read from the head registers at accept time.
    assign addr_page = held;

    pcpa_addr #(
        .PAGE_COUNT (PAGE_COUNT),
        .IDX_W      (IDX_W)
    ) u_addr (
        .i_mem_low   (r_mem_low),
        .i_mem_top   (r_mem_top),
        .i_addr      (r_addr),
        .i_page      (addr_page),
        .o_free_ok   (free_ok),
        .o_free_idx  (free_idx),
        .o_free_link (free_link),
        .o_page_addr (page_addr)
    );

    // Register writes are taken in any cycle outside reset.
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_low <= MEM_LOW_RST;
            r_mem_top <= MEM_TOP_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_MEM_LOW: r_mem_low <= i_cfg.data;
                REG_MEM_TOP: r_mem_top <= i_cfg.data;
                default:     r_mem_low <= r_mem_low;
            endcase
        end
    end

    assign out_free = !r_out_valid || o_rsp.ready;
    assign in_take  = i_req.valid && i_req.ready;

    // Next state and the datapath controls of the sequencer.
    always_comb begin
        n_state         = r_state;
        i_req.ready     = 1'b0;
        head_cmd.latch   = 1'b0;
        head_cmd.is_free = i_req.req_type == REQ_FREE;
        head_cmd.wr_en   = 1'b0;
        head_cmd.wr_val  = free_link;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = IDX_W'(pick.head - LINK_W'(1));
        load_out        = 1'b0;
        n_alloc_addr    = '0;
        n_granted       = 1'b0;
        n_bad_free      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // No request is taken while reset is held.
                i_req.ready = i_rst_n;
                if (i_req.valid && i_rst_n) begin
                    head_cmd.latch = 1'b1;
                    if (i_req.req_type == REQ_FREE) begin
                        n_state = ST_FREE;
                    end else begin
                        // Start the read of the chosen head's successor now.
                        ram_re  = pick.found;
                        n_state = ST_POP;
                    end
                end
            end
            ST_FREE: begin
                if (out_free) begin
                    load_out       = 1'b1;
                    n_bad_free     = !(free_ok && r_cpu_ok);
                    ram_we         = free_ok && r_cpu_ok;
                    head_cmd.wr_en = free_ok && r_cpu_ok;
                    n_state        = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_free) begin
                    load_out        = 1'b1;
                    head_cmd.wr_en  = r_found;
                    head_cmd.wr_val = ram_rdata;
                    n_alloc_addr    = r_found ? page_addr : '0;
                    n_granted       = r_found;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_found  <= pick.found;
            r_cpu_ok <= int'(i_req.cpu_id) < CPU_COUNT;
            r_addr   <= i_req.page_addr;
        end
        if (load_out) begin
            r_alloc_addr <= n_alloc_addr;
            r_granted    <= n_granted;
            r_bad_free   <= n_bad_free;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.alloc_addr = r_alloc_addr;
    assign o_rsp.granted    = r_granted;
    assign o_rsp.bad_free   = r_bad_free;

endmodule

[sim/per_cpu_page_free_list_allocator_tb.sv]
`timescale 1ns / 1ps

module per_cpu_page_free_list_allocator_tb;

    import pcpa_pkg::*;

    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;

    // Cycles the block may still need after its last result before a register
    // write, and at the end of the run.
    localparam int SETTLE_CYCLES = 8;
    // Length of the long receiver hold-off in the backpressure test.
    localparam int HOLD_CYCLES   = 200;
    // The watchdog ends the run after this many cycles without any transaction.
    // A correct run is never quiet for longer than the HOLD_CYCLES hold-off plus
    // random idling, which stays far below this limit.
    localparam int STALL_LIMIT   = 2000;
    // Percentage of cycles in which either side idles.
    localparam int IDLE_PCT      = 23;

    // One result of the block as the predictor expects it.
    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        logic              granted;
        logic              bad_free;
    } t_page_result;

    logic i_clk;
    logic i_rst_n;

    pcpa_req_if req_if ();
    pcpa_rsp_if rsp_if ();
    pcpa_cfg_if cfg_if ();

    per_cpu_page_free_list_allocator #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_COUNT (PAGE_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor state: the bounds registers, the head of every CPU list and the
    // shared link memory. Heads and links hold page number plus one, and zero
    // marks the end of a list. The link memory starts at zero, but no pop ever
    // reads an entry before its page has been pushed.
    logic [ADDR_W-1:0] low_bound;
    logic [ADDR_W-1:0] top_bound;
    logic [LINK_W-1:0] head_of [CPU_COUNT];
    logic [LINK_W-1:0] link_of [PAGE_COUNT];

    t_page_result pending_results [$];
    int           mismatches;
    int           idle_cycles;

    // Pacing controls, changed after initialisation only by nonblocking assignment at a clock edge.
    logic src_steady;
    logic snk_steady;
    logic hold_off;

    // Pops one list in the predictor. Returns the old head, or zero when the
    // list is empty.
    function automatic logic [LINK_W-1:0] take_head(input int c);
        logic [LINK_W-1:0] h;
        h = head_of[c];
        if (h != '0 && h <= PAGE_COUNT) begin
            head_of[c] = link_of[h - 1'b1];
            return h;
        end
        return '0;
    endfunction

    // Works out the result of one request and updates the predictor state.
    function automatic t_page_result predict_request(input logic rt,
                                                     input logic [CPU_ID_W-1:0] cpu,
                                                     input logic [ADDR_W-1:0] a);
        t_page_result      r;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] offset;
        logic [LINK_W-1:0] got;
        int                idx;
        r      = '0;
        base   = (low_bound >> PAGE_SHIFT) << PAGE_SHIFT;
        offset = a - base;
        if (rt == REQ_FREE) begin
            // A bad address or a foreign CPU is flagged and changes nothing.
            if (int'(cpu) >= CPU_COUNT || (a & ADDR_W'(PAGE_BYTES - 1)) != '0 ||
                a < low_bound || a >= top_bound) begin
                r.bad_free = 1'b1;
            end else if ((offset >> PAGE_SHIFT) >= PAGE_COUNT) begin
                // The page lies beyond what the link memory can hold.
                r.bad_free = 1'b1;
            end else begin
                idx          = int'(offset >> PAGE_SHIFT);
                link_of[idx] = head_of[cpu];
                head_of[cpu] = LINK_W'(idx + 1);
            end
        end else begin
            got = '0;
            if (int'(cpu) < CPU_COUNT) begin
                got = take_head(int'(cpu));
            end
            // Own list empty: steal from the lowest-numbered other CPU.
            for (int c = 0; c < CPU_COUNT && got == '0; c++) begin
                if (c != int'(cpu)) begin
                    got = take_head(c);
                end
            end
            if (got != '0) begin
                // Pages are placed relative to the base in force right now,
                // and the address wraps at 40 bits.
                r.alloc_addr = base + (ADDR_W'(got - 1'b1) << PAGE_SHIFT);
                r.granted    = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Monitor and checker. Everything is sampled at the rising edge, before any
    // nonblocking update of that edge lands. A result transaction always
    // belongs to an earlier request, so it is checked before a request of the
    // same edge is predicted.
    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", '0,
                                    {rsp_if.alloc_addr, rsp_if.granted, rsp_if.bad_free});
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.alloc_addr !== want.alloc_addr) begin
                        report_mismatch("alloc_addr", want.alloc_addr, rsp_if.alloc_addr);
                    end
                    if (rsp_if.granted !== want.granted) begin
                        report_mismatch("granted", want.granted, rsp_if.granted);
                    end
                    if (rsp_if.bad_free !== want.bad_free) begin
                        report_mismatch("bad_free", want.bad_free, rsp_if.bad_free);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                pending_results.push_back(predict_request(req_if.req_type, req_if.cpu_id,
                                                          req_if.page_addr));
            end
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == REG_MEM_LOW) begin
                    low_bound = cfg_if.data;
                end else if (cfg_if.index == REG_MEM_TOP) begin
                    top_bound = cfg_if.data;
                end
            end
        end
    end

    // Result side pacing: a long hold-off when asked for, a stretch with no
    // idling, and random idling otherwise.
    always @(posedge i_clk) begin
        if (hold_off) begin
            rsp_if.ready <= 1'b0;
        end else if (snk_steady) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: counts cycles in which no transaction happens on any channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one request and returns at the edge where it is accepted. Valid
    // stays high afterward, so a following request without a gap goes out on
    // the next cycle.
    task automatic issue_request(input logic rt, input logic [CPU_ID_W-1:0] cpu,
                                 input logic [ADDR_W-1:0] a);
        while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rt;
        req_if.cpu_id    <= cpu;
        req_if.page_addr <= a;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops sending, waits for every expected result and lets the block settle.
    task automatic settle_block();
        req_if.valid <= 1'b0;
        // One edge first, so that a request taken at the current edge has
        // already been recorded by the monitor.
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both bounds registers while the block is idle, as two back to back
    // transactions on the configuration channel.
    task automatic write_bounds(input logic [ADDR_W-1:0] low, input logic [ADDR_W-1:0] top);
        settle_block();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_MEM_LOW;
        cfg_if.data  <= low;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        cfg_if.index <= REG_MEM_TOP;
        cfg_if.data  <= top;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Random traffic. Most frees name a real page inside the current window, so
    // the lists grow and shrink and stealing happens. The rest are double frees
    // from a small pool, unaligned addresses, addresses at the bounds and raw
    // 40-bit noise. Allocates carry a random address that must be ignored.
    task automatic random_traffic(input int n, input int alloc_pct);
        logic [63:0]       noise;
        logic [ADDR_W:0]   first;
        logic [ADDR_W:0]   cap;
        logic [ADDR_W:0]   stop;
        int unsigned       count;
        int unsigned       pool;
        int                kind;
        logic              rt;
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < n; i++) begin
            first = (({1'b0, low_bound} + PAGE_BYTES - 1) >> PAGE_SHIFT) << PAGE_SHIFT;
            cap   = (({1'b0, low_bound} >> PAGE_SHIFT) << PAGE_SHIFT) + (PAGE_COUNT << PAGE_SHIFT);
            stop  = (cap < {1'b0, top_bound}) ? cap : {1'b0, top_bound};
            count = (stop > first) ? int'((stop - first) >> PAGE_SHIFT) : 0;
            pool  = (count < 16) ? count : 16;
            noise = {$urandom, $urandom};
            a     = noise[ADDR_W-1:0];
            rt    = ($urandom_range(99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
            if (rt == REQ_FREE) begin
                kind = $urandom_range(99);
                if (count != 0 && kind < 78) begin
                    a = ADDR_W'(first + ($urandom_range(count - 1) << PAGE_SHIFT));
                end else if (pool != 0 && kind < 84) begin
                    a = ADDR_W'(first + ($urandom_range(pool - 1) << PAGE_SHIFT));
                end else if (kind < 89) begin
                    a = ADDR_W'(first) + ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
                end else if (kind < 93) begin
                    a = top_bound;
                end else if (kind < 96) begin
                    a = ADDR_W'(first) - ADDR_W'(PAGE_BYTES);
                end
            end
            issue_request(rt, CPU_ID_W'($urandom_range(CPU_COUNT - 1)), a);
        end
    endtask

    // Reset bounds: empty lists, unaligned and out-of-window addresses, the lowest
    // and the highest page, LIFO order, stealing in CPU order and a page freed twice.
    task automatic test_reset_defaults();
        logic [ADDR_W-1:0] pg;
        pg = MEM_LOW_RST + ADDR_W'(100 * PAGE_BYTES);
        issue_request(REQ_ALLOC, 3'd0, '0);
        issue_request(REQ_ALLOC, 3'd7, '1);
        issue_request(REQ_FREE, 3'd0, '0);
        issue_request(REQ_FREE, 3'd1, '1);
        issue_request(REQ_FREE, 3'd1, MEM_LOW_RST + 1'b1);
        issue_request(REQ_FREE, 3'd1, MEM_LOW_RST - ADDR_W'(PAGE_BYTES));
        issue_request(REQ_FREE, 3'd2, MEM_TOP_RST);
        issue_request(REQ_FREE, 3'd2, MEM_TOP_RST - ADDR_W'(PAGE_BYTES));
        issue_request(REQ_FREE, 3'd5, MEM_LOW_RST);
        issue_request(REQ_FREE, 3'd5, MEM_LOW_RST + ADDR_W'(7 * PAGE_BYTES));
        issue_request(REQ_ALLOC, 3'd5, '0);
        issue_request(REQ_ALLOC, 3'd5, '0);
        // CPU 5 is empty now and steals the top page from CPU 2.
        issue_request(REQ_ALLOC, 3'd5, '0);
        issue_request(REQ_ALLOC, 3'd5, '0);
        // The same page freed by two CPUs: the second push overwrites its link.
        issue_request(REQ_FREE, 3'd3, pg);
        issue_request(REQ_FREE, 3'd4, pg);
        issue_request(REQ_ALLOC, 3'd3, '0);
        issue_request(REQ_ALLOC, 3'd4, '0);
        // Stealing picks the lowest-numbered CPU that has a page.
        issue_request(REQ_FREE, 3'd6, pg + ADDR_W'(PAGE_BYTES));
        issue_request(REQ_FREE, 3'd2, pg + ADDR_W'(2 * PAGE_BYTES));
        issue_request(REQ_ALLOC, 3'd7, '0);
        issue_request(REQ_ALLOC, 3'd7, '0);
        issue_request(REQ_ALLOC, 3'd1, '0);
    endtask

    task automatic test_mixed_traffic();
        random_traffic(400, 50);
    endtask

    // A long stretch where neither side idles, so requests go out back to back
    // and pushes can be followed at once by pops of the same list.
    task automatic test_back_to_back();
        src_steady <= 1'b1;
        snk_steady <= 1'b1;
        random_traffic(150, 45);
        src_steady <= 1'b0;
        snk_steady <= 1'b0;
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so
    // the block fills and stalls its input. Then the sender pauses until every
    // result has arrived.
    task automatic test_output_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        random_traffic(30, 40);
        settle_block();
    endtask

    // Several bound settings, the extremes among them. Pages left on the lists
    // from one setting come back relative to the base of the next.
    task automatic test_register_settings();
        // Unaligned low bound: the base is rounded down below it.
        write_bounds(40'h00_1234_5678, 40'h00_1334_5678);
        issue_request(REQ_FREE, 3'd4, 40'h00_1234_5678);
        issue_request(REQ_FREE, 3'd4, 40'h00_1234_5000);
        issue_request(REQ_FREE, 3'd4, 40'h00_1234_6000);
        issue_request(REQ_ALLOC, 3'd4, '0);
        random_traffic(150, 50);

        // Widest window: only the link memory size limits which pages fit.
        write_bounds('0, '1);
        issue_request(REQ_FREE, 3'd0, ADDR_W'(PAGE_COUNT) << PAGE_SHIFT);
        issue_request(REQ_FREE, 3'd0, ADDR_W'(PAGE_COUNT - 1) << PAGE_SHIFT);
        issue_request(REQ_FREE, 3'd0, '0);
        issue_request(REQ_ALLOC, 3'd0, '0);
        random_traffic(150, 50);

        // Inverted bounds: every free is refused, allocates drain old pages
        // with addresses that wrap at the top of the address space.
        write_bounds('1, '0);
        random_traffic(60, 70);

        // A window of only a few pages at the top of the address space.
        write_bounds(40'hFF_FFFF_0000, '1);
        issue_request(REQ_FREE, 3'd6, 40'hFF_FFFF_F000);
        issue_request(REQ_ALLOC, 3'd6, '0);
        random_traffic(100, 50);

        write_bounds(MEM_LOW_RST, MEM_TOP_RST);
        random_traffic(200, 55);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_ALLOC;
        req_if.cpu_id    = '0;
        req_if.page_addr = '0;
        rsp_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_MEM_LOW;
        cfg_if.data      = '0;
        src_steady       = 1'b0;
        snk_steady       = 1'b0;
        hold_off         = 1'b0;
        mismatches       = 0;
        idle_cycles      = 0;
        low_bound        = MEM_LOW_RST;
        top_bound        = MEM_TOP_RST;
        for (int c = 0; c < CPU_COUNT; c++) begin
            head_of[c] = '0;
        end
        for (int p = 0; p < PAGE_COUNT; p++) begin
            link_of[p] = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_mixed_traffic();
        test_back_to_back();
        test_output_backpressure();
        test_register_settings();

        // Wait for the last results and let the block settle, so that any result
        // the predictor does not expect would still be caught.
        settle_block();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[per_cpu_page_free_list_allocator.f]
rtl/pcpa_pkg.sv
rtl/pcpa_if.sv
rtl/pcpa_ram.sv
rtl/pcpa_heads.sv
rtl/pcpa_addr.sv
rtl/per_cpu_page_free_list_allocator.sv
sim/per_cpu_page_free_list_allocator_tb.sv
